/* hw/rtl/sme_pkg.sv */
package sme_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 1024;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned ACT_W           = 4;
	localparam int unsigned DEPTH_W         = 11;

	// action codes
	localparam logic [ACT_W-1:0] OP_PUSH = 4'd0;
	localparam logic [ACT_W-1:0] OP_ADD  = 4'd1;
	localparam logic [ACT_W-1:0] OP_SUB  = 4'd2;
	localparam logic [ACT_W-1:0] OP_MUL  = 4'd3;
	localparam logic [ACT_W-1:0] OP_DIV  = 4'd4;
	localparam logic [ACT_W-1:0] OP_EQ   = 4'd5;
	localparam logic [ACT_W-1:0] OP_DUP  = 4'd6;
	localparam logic [ACT_W-1:0] OP_SWAP = 4'd7;
	localparam logic [ACT_W-1:0] OP_DUMP = 4'd8;
	localparam logic [ACT_W-1:0] OP_IF   = 4'd9;
	localparam logic [ACT_W-1:0] OP_END  = 4'd10;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_FULL = 3'd1,
		ST_FEW  = 3'd2,
		ST_DIVZ = 3'd3,
		ST_SKIP = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_B,
		S_RD_A,
		S_SWAP2,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_TOP,
		ADDR_NEXT,
		ADDR_FREE
	} addr_sel_t;

	typedef enum logic [2:0] {
		WD_VALUE,
		WD_RD,
		WD_ALU,
		WD_ZERO,
		WD_B,
		WD_QUOT
	} wd_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		SKIP_HOLD,
		SKIP_CLR,
		SKIP_FROM_RD
	} skip_op_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_EQ
	} alu_op_t;

	typedef struct packed {
		logic      accept;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      wr_en;
		addr_sel_t wr_sel;
		wd_sel_t   wd_sel;
		cnt_op_t   cnt_op;
		skip_op_t  skip_op;
		logic      cap_b;
		logic      set_st;
		status_t   st;
		logic      set_top;
		logic      div_start;
		alu_op_t   alu_op;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_lt2;
		logic cnt_full;
		logic skip;
		logic b_zero;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

/* hw/rtl/sme_div.sv */
// Signed 32-bit divider, restoring, one quotient bit per cycle.
module sme_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sme_pkg::DATA_W-1:0]    dividend,
	input  logic [sme_pkg::DATA_W-1:0]    divisor,
	output logic                          done,
	output logic [sme_pkg::DATA_W-1:0]    quot
);

	localparam int unsigned W  = sme_pkg::DATA_W;
	localparam int unsigned SW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic          neg_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(W - 1);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
			dsr_q <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

/* hw/rtl/sme_dpath.sv */
// Stack memory, depth counter, skip flag, ALU, divider and result register.
module sme_dpath #(
	parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sme_pkg::cmd_t                  cmd,
	output sme_pkg::stat_t                 stat,
	input  logic [sme_pkg::DATA_W-1:0]     value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     out_status,
	output logic                           out_has_value,
	output logic [sme_pkg::DATA_W-1:0]     out_top,
	output logic [sme_pkg::DEPTH_W-1:0]    out_depth
);

	localparam int unsigned W  = sme_pkg::DATA_W;
	localparam int unsigned DW = sme_pkg::DEPTH_W;
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [W-1:0]       mem [STACK_DEPTH];
	logic [W-1:0]       rd_data_q;
	logic [W-1:0]       b_q;
	logic [W-1:0]       value_q;
	logic [CW-1:0]      cnt_q;
	logic               skip_q;
	sme_pkg::status_t   res_st_q;
	logic               res_hv_q;
	logic [W-1:0]       res_top_q;
	logic               out_valid_q;
	logic [2:0]         out_st_q;
	logic               out_hv_q;
	logic [W-1:0]       out_top_q;
	logic [DW-1:0]      out_depth_q;
	logic [CW-1:0]      rd_full;
	logic [CW-1:0]      wr_full;
	logic [W-1:0]       wr_data;
	logic [W-1:0]       alu_res;
	logic [W-1:0]       quot;
	logic               div_done;
	logic [CW+DW-1:0]   cnt_ext;

	function automatic logic [CW-1:0] sel_addr(sme_pkg::addr_sel_t sel, logic [CW-1:0] cnt);
		logic [CW-1:0] a;
		unique case (sel)
			sme_pkg::ADDR_TOP:  a = cnt - CW'(1);
			sme_pkg::ADDR_NEXT: a = cnt - CW'(2);
			sme_pkg::ADDR_FREE: a = cnt;
			default:            a = cnt;
		endcase
		return a;
	endfunction

	assign rd_full = sel_addr(cmd.rd_sel, cnt_q);
	assign wr_full = sel_addr(cmd.wr_sel, cnt_q);

	// a = rd_data_q, b = b_q
	always_comb begin
		unique case (cmd.alu_op)
			sme_pkg::ALU_ADD: alu_res = rd_data_q + b_q;
			sme_pkg::ALU_SUB: alu_res = rd_data_q - b_q;
			sme_pkg::ALU_MUL: alu_res = rd_data_q * b_q;
			sme_pkg::ALU_EQ:  alu_res = (rd_data_q == b_q) ? W'(1) : W'(0);
			default:          alu_res = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wd_sel)
			sme_pkg::WD_VALUE: wr_data = value_q;
			sme_pkg::WD_RD:    wr_data = rd_data_q;
			sme_pkg::WD_ALU:   wr_data = alu_res;
			sme_pkg::WD_ZERO:  wr_data = '0;
			sme_pkg::WD_B:     wr_data = b_q;
			sme_pkg::WD_QUOT:  wr_data = quot;
			default:           wr_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_full[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_full[AW-1:0]];
		end
	end

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_data_q),
		.divisor  (b_q),
		.done     (div_done),
		.quot     (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q <= value;
		end
		if (cmd.cap_b) begin
			b_q <= rd_data_q;
		end
		if (cmd.accept) begin
			res_st_q  <= sme_pkg::ST_OK;
			res_hv_q  <= 1'b0;
			res_top_q <= '0;
		end else begin
			if (cmd.set_st) begin
				res_st_q <= cmd.st;
			end
			if (cmd.set_top) begin
				res_hv_q  <= 1'b1;
				res_top_q <= rd_data_q;
			end
		end
		if (cmd.load_out) begin
			out_st_q    <= res_st_q;
			out_hv_q    <= res_hv_q;
			out_top_q   <= res_top_q;
			out_depth_q <= cnt_ext[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				sme_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
				sme_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
				default:          cnt_q <= cnt_q;
			endcase
			unique case (cmd.skip_op)
				sme_pkg::SKIP_CLR:     skip_q <= 1'b0;
				sme_pkg::SKIP_FROM_RD: skip_q <= (rd_data_q == '0);
				default:               skip_q <= skip_q;
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext = {{DW{1'b0}}, cnt_q};

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.cnt_lt2  = (cnt_q < CW'(2));
	assign stat.cnt_full = (cnt_q >= CW'(STACK_DEPTH));
	assign stat.skip     = skip_q;
	assign stat.b_zero   = (b_q == '0);
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_status    = out_st_q;
	assign out_has_value = out_hv_q;
	assign out_top       = out_top_q;
	assign out_depth     = out_depth_q;

endmodule

/* hw/rtl/sme_ctrl.sv */
// Sequencer: decodes the action and steps the datapath through it.
module sme_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sme_pkg::ACT_W-1:0]   action,
	input  sme_pkg::stat_t              stat,
	output sme_pkg::cmd_t               cmd
);

	sme_pkg::state_t          state_q;
	sme_pkg::state_t          state_d;
	logic [sme_pkg::ACT_W-1:0] act_q;
	sme_pkg::status_t          ex_st;
	logic                      ex_rd;
	sme_pkg::alu_op_t          alu_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::S_IDLE;
			act_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				act_q <= action;
			end
		end
	end

	// first-cycle checks: status on failure, and whether the top entry is needed
	always_comb begin
		ex_st = sme_pkg::ST_OK;
		ex_rd = 1'b0;
		if (stat.skip && act_q != sme_pkg::OP_END) begin
			ex_st = sme_pkg::ST_SKIP;
		end else begin
			unique case (act_q)
				sme_pkg::OP_PUSH: begin
					if (stat.cnt_full) ex_st = sme_pkg::ST_FULL;
				end
				sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
				sme_pkg::OP_EQ, sme_pkg::OP_SWAP: begin
					if (stat.cnt_lt2) ex_st = sme_pkg::ST_FEW;
					else ex_rd = 1'b1;
				end
				sme_pkg::OP_DUP: begin
					if (stat.cnt_zero) ex_st = sme_pkg::ST_FEW;
					else if (stat.cnt_full) ex_st = sme_pkg::ST_FULL;
					else ex_rd = 1'b1;
				end
				sme_pkg::OP_DUMP, sme_pkg::OP_IF: begin
					if (stat.cnt_zero) ex_st = sme_pkg::ST_FEW;
					else ex_rd = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (act_q)
			sme_pkg::OP_ADD: alu_op = sme_pkg::ALU_ADD;
			sme_pkg::OP_SUB: alu_op = sme_pkg::ALU_SUB;
			sme_pkg::OP_MUL: alu_op = sme_pkg::ALU_MUL;
			default:         alu_op = sme_pkg::ALU_EQ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sme_pkg::S_IDLE: begin
				if (in_valid) state_d = sme_pkg::S_EXEC;
			end
			sme_pkg::S_EXEC: begin
				state_d = ex_rd ? sme_pkg::S_RD_B : sme_pkg::S_DONE;
			end
			sme_pkg::S_RD_B: begin
				if (act_q == sme_pkg::OP_DUP || act_q == sme_pkg::OP_DUMP ||
				    act_q == sme_pkg::OP_IF) begin
					state_d = sme_pkg::S_DONE;
				end else begin
					state_d = sme_pkg::S_RD_A;
				end
			end
			sme_pkg::S_RD_A: begin
				if (act_q == sme_pkg::OP_SWAP) begin
					state_d = sme_pkg::S_SWAP2;
				end else if (act_q == sme_pkg::OP_DIV && !stat.b_zero) begin
					state_d = sme_pkg::S_DIV_WAIT;
				end else begin
					state_d = sme_pkg::S_DONE;
				end
			end
			sme_pkg::S_SWAP2: begin
				state_d = sme_pkg::S_DONE;
			end
			sme_pkg::S_DIV_WAIT: begin
				if (stat.div_done) state_d = sme_pkg::S_DONE;
			end
			sme_pkg::S_DONE: begin
				if (stat.out_free) state_d = sme_pkg::S_IDLE;
			end
			default: state_d = sme_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.rd_sel    = sme_pkg::ADDR_TOP;
		cmd.wr_sel    = sme_pkg::ADDR_TOP;
		cmd.wd_sel    = sme_pkg::WD_ZERO;
		cmd.cnt_op    = sme_pkg::CNT_HOLD;
		cmd.skip_op   = sme_pkg::SKIP_HOLD;
		cmd.st        = sme_pkg::ST_OK;
		cmd.alu_op    = alu_op;
		unique case (state_q)
			sme_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			sme_pkg::S_EXEC: begin
				cmd.set_st = (ex_st != sme_pkg::ST_OK);
				cmd.st     = ex_st;
				cmd.rd_en  = ex_rd;
				if (ex_st == sme_pkg::ST_OK && act_q == sme_pkg::OP_PUSH) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sme_pkg::ADDR_FREE;
					cmd.wd_sel = sme_pkg::WD_VALUE;
					cmd.cnt_op = sme_pkg::CNT_INC;
				end
				if (ex_st == sme_pkg::ST_OK && act_q == sme_pkg::OP_END) begin
					cmd.skip_op = sme_pkg::SKIP_CLR;
				end
			end
			sme_pkg::S_RD_B: begin
				cmd.cap_b = 1'b1;
				if (act_q == sme_pkg::OP_DUP) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sme_pkg::ADDR_FREE;
					cmd.wd_sel = sme_pkg::WD_RD;
					cmd.cnt_op = sme_pkg::CNT_INC;
				end else if (act_q == sme_pkg::OP_DUMP) begin
					cmd.set_top = 1'b1;
				end else if (act_q == sme_pkg::OP_IF) begin
					cmd.skip_op = sme_pkg::SKIP_FROM_RD;
					cmd.cnt_op  = sme_pkg::CNT_DEC;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = sme_pkg::ADDR_NEXT;
				end
			end
			sme_pkg::S_RD_A: begin
				if (act_q == sme_pkg::OP_SWAP) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sme_pkg::ADDR_TOP;
					cmd.wd_sel = sme_pkg::WD_RD;
				end else if (act_q == sme_pkg::OP_DIV) begin
					if (stat.b_zero) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = sme_pkg::ADDR_TOP;
						cmd.wd_sel = sme_pkg::WD_ZERO;
						cmd.set_st = 1'b1;
						cmd.st     = sme_pkg::ST_DIVZ;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sme_pkg::ADDR_NEXT;
					cmd.wd_sel = sme_pkg::WD_ALU;
					cmd.cnt_op = sme_pkg::CNT_DEC;
				end
			end
			sme_pkg::S_SWAP2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = sme_pkg::ADDR_NEXT;
				cmd.wd_sel = sme_pkg::WD_B;
			end
			sme_pkg::S_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = sme_pkg::ADDR_NEXT;
					cmd.wd_sel = sme_pkg::WD_QUOT;
					cmd.cnt_op = sme_pkg::CNT_DEC;
				end
			end
			sme_pkg::S_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/stack_machine_executor_top.sv */
// Channel   Dir  Signals                 Contents
// s_axis    in   tvalid/tready/tdata     tdata[31:0] value
//                tuser                   tuser[3:0] action
// m_axis    out  tvalid/tready/tdata     tdata[31:0] top_value, [42:32] depth, [47:43] zero
//                tuser                   tuser[2:0] status, [3] has_value
//
// One operation at a time. Push, end, skipped and failed actions go from S_EXEC
// to S_DONE; dup, dump and if read the top entry in S_RD_B; add, sub, mul, equal,
// swap and div then read the next entry in S_RD_A; swap writes in S_SWAP2 and div
// waits in S_DIV_WAIT. Reads use the single registered read port of the stack memory.
// arst_n clears depth, skip flag, sequencer and output valid; stack contents
// are not cleared. The result register lets a new transfer be taken while a
// result waits; a stalled m_axis holds the sequencer in its last state.
module stack_machine_executor_top #(
	parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic [3:0]  s_axis_tuser,   // [3:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] top_value, [42:32] depth, [47:43] zero
	output logic [3:0]  m_axis_tuser    // [2:0] status, [3] has_value
);

	sme_pkg::cmd_t                    cmd;
	sme_pkg::stat_t                   stat;
	logic [2:0]                       out_status;
	logic                             out_has_value;
	logic [sme_pkg::DATA_W-1:0]       out_top;
	logic [sme_pkg::DEPTH_W-1:0]      out_depth;

	// sequencer
	sme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.action   (s_axis_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack, arithmetic and result register
	sme_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.value         (s_axis_tdata),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (out_status),
		.out_has_value (out_has_value),
		.out_top       (out_top),
		.out_depth     (out_depth)
	);

	assign m_axis_tdata = {5'b0, out_depth, out_top};
	assign m_axis_tuser = {out_has_value, out_status};

endmodule

/* hw/rtl/sme_checker.sv */
module sme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one operation in flight: no transfer on the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken back to back");

	a_hv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == sme_pkg::ST_OK)
		else $error("dumped value with failing status");

	a_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("top_value set without has_value");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] <= sme_pkg::ST_SKIP)
		else $error("status code out of range");

endmodule

bind stack_machine_executor_top sme_checker u_sme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

/* bench/stack_machine_executor_top_test.sv */
`timescale 1ns / 100ps

import sme_pkg::*;

// One expected result: status, optional dumped word, depth after the op.
typedef struct packed {
	status_t     status;
	logic        has_value;
	logic [31:0] top_value;
	logic [10:0] depth;
} op_outcome_t;

// Shadow stack plus the queue of results still owed by the block.
class stack_checker;
	localparam int unsigned DEPTH_MAX = STACK_DEPTH_DEF;
	localparam int unsigned MAX_REPORTS = 200;

	logic [31:0]   words [0:DEPTH_MAX-1];
	int unsigned   fill;
	bit            skipping;
	op_outcome_t   outcomes[$];
	int unsigned   mismatches;

	function new();
		fill = 0;
		skipping = 1'b0;
		mismatches = 0;
	endfunction

	function int unsigned depth();
		return fill;
	endfunction

	function int unsigned outstanding();
		return outcomes.size();
	endfunction

	// Two-operand arithmetic, 32-bit wrap; division truncates toward zero.
	function logic [31:0] combine(logic [3:0] act, logic [31:0] a, logic [31:0] b);
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] quot;
		case (act)
		OP_ADD: return a + b;
		OP_SUB: return a - b;
		OP_MUL: return a * b;
		OP_DIV: begin
			mag_a = a[31] ? -a : a;
			mag_b = b[31] ? -b : b;
			quot = mag_a / mag_b;
			return (a[31] ^ b[31]) ? -quot : quot;
		end
		default: return (a == b) ? 32'd1 : 32'd0;
		endcase
	endfunction

	// Called once per accepted input transfer.
	function void apply_op(logic [3:0] act, logic [31:0] val);
		op_outcome_t o;
		logic [31:0] a;
		logic [31:0] b;
		int unsigned n;
		o.status = ST_OK;
		o.has_value = 1'b0;
		o.top_value = '0;
		n = fill;
		if (skipping && act != OP_END) begin
			o.status = ST_SKIP;
		end else begin
			case (act)
			OP_PUSH: begin
				if (n >= DEPTH_MAX) begin
					o.status = ST_FULL;
				end else begin
					words[n] = val;
					fill = n + 1;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
				if (n < 2) begin
					o.status = ST_FEW;
				end else begin
					b = words[n-1];
					a = words[n-2];
					if (act == OP_DIV && b == '0) begin
						// divisor replaced by zero, dividend kept
						words[n-1] = '0;
						o.status = ST_DIVZ;
					end else begin
						words[n-2] = combine(act, a, b);
						fill = n - 1;
					end
				end
			end
			OP_DUP: begin
				if (n == 0) begin
					o.status = ST_FEW;
				end else if (n >= DEPTH_MAX) begin
					o.status = ST_FULL;
				end else begin
					words[n] = words[n-1];
					fill = n + 1;
				end
			end
			OP_SWAP: begin
				if (n < 2) begin
					o.status = ST_FEW;
				end else begin
					a = words[n-1];
					words[n-1] = words[n-2];
					words[n-2] = a;
				end
			end
			OP_DUMP: begin
				if (n == 0) begin
					o.status = ST_FEW;
				end else begin
					o.has_value = 1'b1;
					o.top_value = words[n-1];
				end
			end
			OP_IF: begin
				if (n == 0) begin
					o.status = ST_FEW;
				end else begin
					skipping = (words[n-1] == '0);
					fill = n - 1;
				end
			end
			OP_END: skipping = 1'b0;
			default: ;  // unused codes: no effect, ok
			endcase
		end
		o.depth = DEPTH_W'(fill);
		outcomes.push_back(o);
	endfunction

	function void flag(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endfunction

	// Called once per accepted output transfer.
	function void check_result(logic [47:0] data, logic [3:0] user);
		op_outcome_t o;
		if (outcomes.size() == 0) begin
			flag("result with nothing pending", '0, 64'({user, data}));
			return;
		end
		o = outcomes.pop_front();
		if (user[2:0] !== o.status)
			flag("status", 64'(o.status), 64'(user[2:0]));
		if (user[3] !== o.has_value)
			flag("has_value", 64'(o.has_value), 64'(user[3]));
		if (data[31:0] !== o.top_value)
			flag("top_value", 64'(o.top_value), 64'(data[31:0]));
		if (data[42:32] !== o.depth)
			flag("depth", 64'(o.depth), 64'(data[42:32]));
		if (data[47:43] !== 5'd0)
			flag("tdata padding", '0, 64'(data[47:43]));
	endfunction
endclass

module stack_machine_executor_top_test;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_OPS   = 450;
	localparam int unsigned STRETCH      = 50;    // ops per idling decision
	localparam int unsigned DRAIN_CYCLES = 60;    // longer than a divide
	localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;
	localparam logic [ACT_W-1:0] FIRST_UNUSED_OP = OP_END + ACT_W'(1);
	localparam logic [ACT_W-1:0] LAST_CODE       = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic [3:0]  s_axis_tuser = '0;   // [3:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [31:0] top_value, [42:32] depth, [47:43] zero
	logic [3:0]  m_axis_tuser;        // [2:0] status, [3] has_value

	// Idling switches: sender gaps and receiver stalls, set per stretch.
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;

	stack_checker sb = new();

	always #2 clk = ~clk;

	stack_machine_executor_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Data values lean hard on the corners: zero (skips, divide by zero),
	// the signed extremes (wrap, INT_MIN / -1) and small signed numbers.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return 32'd1;
		2: return '1;
		3: return WORD_MIN;
		4: return WORD_MAX;
		5: return $urandom_range(0, 20) - 10;
		default: return $urandom;
		endcase
	endfunction

	// Drive one op and hold it until the transfer. tvalid stays high on
	// return so back-to-back ops need no extra edge; the predictor is
	// updated at the edge of the transfer, so the stimulus can steer on it.
	task automatic issue(logic [3:0] act, logic [31:0] val);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= val;
		do @(posedge clk); while (!s_axis_tready);
		sb.apply_op(act, val);
	endtask

	// Receiver: random stall bursts while enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result monitor: values sampled at the edge are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stack_machine_executor_top_test failed");
		$finish;
	end

	initial begin
		logic [3:0] binops [0:4];
		logic [3:0] act;
		int unsigned push_pct;
		int unsigned pick;
		binops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed corners ---
		// empty stack: one-operand ops report too few
		issue(OP_DUMP, $urandom);
		issue(OP_DUP, $urandom);
		issue(OP_IF, $urandom);
		issue(OP_PUSH, WORD_MAX);
		issue(OP_SWAP, $urandom);            // one entry, two needed
		issue(OP_PUSH, 32'd1);
		issue(OP_ADD, $urandom);             // MAX + 1 wraps to MIN
		issue(OP_PUSH, '1);
		issue(OP_DIV, $urandom);             // MIN / -1 wraps to MIN
		issue(OP_PUSH, '0);
		issue(OP_DIV, $urandom);             // zero divisor
		issue(OP_SWAP, $urandom);
		issue(OP_DUMP, $urandom);
		issue(OP_SUB, $urandom);             // 0 - MIN wraps
		issue(OP_PUSH, 32'hFFFF_FFF9);
		issue(OP_PUSH, 32'd2);
		issue(OP_DIV, $urandom);             // -7 / 2 truncates to -3
		issue(OP_MUL, $urandom);             // wrapping multiply
		issue(OP_DUP, $urandom);
		issue(OP_EQ, $urandom);              // equal -> 1
		issue(OP_PUSH, '0);
		issue(OP_IF, $urandom);              // zero condition starts skip
		issue(OP_PUSH, 32'd5);               // skipped
		issue(LAST_CODE, $urandom);          // unused code while skipping
		issue(OP_END, $urandom);             // clears skip
		issue(FIRST_UNUSED_OP, $urandom);    // unused code, no skip: ok
		issue(OP_IF, $urandom);              // nonzero condition, no skip

		// --- random ops, steered by the shadow depth ---
		// Push rate follows depth so most ops find their operands; skips
		// get an end within a few ops, with junk codes mixed in meanwhile.
		for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
			if (i % STRETCH == 0) begin
				gaps_on = ($urandom_range(0, 2) != 0);
				stalls_on = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 99);
			push_pct = (sb.depth() < 2) ? 65 : (sb.depth() > 16) ? 15 : 40;
			if (sb.skipping) begin
				act = (pick < 30) ? OP_END : ACT_W'($urandom_range(0, LAST_CODE));
			end else if (pick < push_pct) begin
				act = OP_PUSH;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					act = binops[pick % 5];
				else if (pick < 53)
					act = OP_DUP;
				else if (pick < 61)
					act = OP_SWAP;
				else if (pick < 71)
					act = OP_DUMP;
				else if (pick < 83)
					act = OP_IF;
				else if (pick < 93)
					act = OP_END;
				else
					act = ACT_W'($urandom_range(FIRST_UNUSED_OP, LAST_CODE));
			end
			issue(act, (act == OP_PUSH) ? random_word() : $urandom);
		end

		// --- full stack, no idling from here on ---
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		issue(OP_END, $urandom);
		while (sb.depth() < STACK_DEPTH_DEF)
			issue(OP_PUSH, random_word());
		issue(OP_PUSH, random_word());       // full
		issue(OP_DUP, $urandom);             // full
		issue(OP_DUMP, $urandom);
		issue(OP_SWAP, $urandom);
		issue(OP_ADD, $urandom);
		issue(OP_DUP, $urandom);             // back to full depth
		issue(OP_PUSH, random_word());       // full again
		issue(OP_DIV, $urandom);
		issue(OP_IF, $urandom);
		s_axis_tvalid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("stack_machine_executor_top_test passed");
		else
			$display("stack_machine_executor_top_test failed");
		$finish;
	end

endmodule
